### src/lic_pkg.sv
// Shared constants, types and the table hash helper function of the lossless image chunk decoder.
`timescale 1ns / 1ps
package lic_pkg;

   localparam int PIXEL_COUNT_BITS = 24;
   localparam int TABLE_DEPTH      = 64;
   localparam int TABLE_ADDR_BITS  = $clog2(TABLE_DEPTH);
   localparam int PIXEL_BITS       = 32;

   typedef logic [PIXEL_COUNT_BITS-1:0] count_type;
   typedef logic [7:0]                  chan_type;

   localparam chan_type BYTE_RGB   = 8'd254;
   localparam chan_type BYTE_RGBA  = 8'd255;
   localparam chan_type ALPHA_INIT = 8'd255;

   function automatic logic [TABLE_ADDR_BITS-1:0] hash_term(chan_type c, logic [1:0] ch);
      logic [7:0] t;
      begin
         unique case (ch)
            2'd0: t = 8'(c * 8'd3);
            2'd1: t = 8'(c * 8'd5);
            2'd2: t = 8'(c * 8'd7);
            2'd3: t = 8'(c * 8'd11);
            default: t = '0;
         endcase
         return t[TABLE_ADDR_BITS-1:0];
      end
   endfunction

endpackage

### src/lic_if.sv
// Valid/ready channel interfaces for chunk bytes, decoded pixels and the pixel count register.
`timescale 1ns / 1ps
interface lic_req_if;
   import lic_pkg::*;
   logic     valid;
   logic     ready;
   chan_type chunk_byte;
   logic     first_byte;
   modport source (output valid, output chunk_byte, output first_byte, input ready);
   modport sink (input valid, input chunk_byte, input first_byte, output ready);
endinterface

interface lic_rsp_if;
   import lic_pkg::*;
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;
   chan_type alpha;
   logic     last_of_byte;
   logic     image_end;
   modport source (output valid, output red, output green, output blue, output alpha,
                   output last_of_byte, output image_end, input ready);
   modport sink (input valid, input red, input green, input blue, input alpha,
                 input last_of_byte, input image_end, output ready);
endinterface

interface lic_csr_if;
   import lic_pkg::*;
   logic      valid;
   logic      ready;
   count_type pixel_count;
   modport source (output valid, output pixel_count, input ready);
   modport sink (input valid, input pixel_count, output ready);
endinterface

### src/lic_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lossless_image_chunk_decoder.sv
// Top level: chunk byte decoder with shared 8-bit adder for channel deltas and table hash.
// A byte is decoded in DECODE; index chunks then read the color table in FETCH, diff and
// luma chunks add the red, green and blue deltas in ADD on the shared adder, and every
// pixel chunk sums the four hash terms in HASH on the shared adder before EMIT offers it.
// A byte that completes no chunk returns to IDLE after DECODE; the block is not ready
// while a chunk is in flight, until the last pixel of the byte has been taken.
// Synchronous active-high reset: pixel count 1, no image active, color table marked empty.
`timescale 1ns / 1ps
module lossless_image_chunk_decoder (
   input logic       clock,
   input logic       reset,
   lic_req_if.sink   req,
   lic_rsp_if.source rsp,
   lic_csr_if.sink   csr
);
   import lic_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_ADD,
      ST_HASH,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_RGB,
      KIND_RGBA,
      KIND_LUMA
   } kind_type;

   state_type                 state_ff, state_in;
   kind_type                  kind_ff, kind_in;
   chan_type                  byte_ff, byte_in;
   count_type                 pixel_count_ff, pixel_count_in;
   count_type                 left_ff, left_in;
   logic [2:0]                pend_ff, pend_in;
   logic [5:0]                luma_ff, luma_in;
   chan_type                  prev_ff [4];
   chan_type                  prev_in [4];
   chan_type                  delta_ff [3];
   chan_type                  delta_in [3];
   logic [1:0]                ch_ff, ch_in;
   logic [TABLE_ADDR_BITS-1:0] acc_ff, acc_in;
   logic [5:0]                copies_ff, copies_in;
   logic [TABLE_DEPTH-1:0]    tvalid_ff, tvalid_in;
   logic                      fetch_valid_ff, fetch_valid_in;

   chan_type                  op_a, op_b, sum;
   logic [2:0]                rgb_ch;
   chan_type                  luma_dg;
   logic                      wr_en;
   logic [PIXEL_BITS-1:0]     rd_data;

   lic_ram #(
      .WIDTH (PIXEL_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (sum[TABLE_ADDR_BITS-1:0]),
      .wr_data ({prev_ff[3], prev_ff[2], prev_ff[1], prev_ff[0]}),
      .rd_addr (byte_ff[TABLE_ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (state_ff)
         ST_ADD: begin
            op_a = prev_ff[ch_ff];
            op_b = (ch_ff == 2'd3) ? 8'd0 : delta_ff[ch_ff];
         end
         ST_HASH: begin
            op_a = {{(8-TABLE_ADDR_BITS){1'b0}}, acc_ff};
            op_b = {{(8-TABLE_ADDR_BITS){1'b0}}, hash_term(prev_ff[ch_ff], ch_ff)};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
      sum = op_a + op_b;
   end

   assign rgb_ch  = ((kind_ff == KIND_RGB) ? 3'd3 : 3'd4) - pend_ff;
   assign luma_dg = {2'b00, luma_ff} - 8'd32;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      byte_in        = byte_ff;
      pixel_count_in = pixel_count_ff;
      left_in        = left_ff;
      pend_in        = pend_ff;
      luma_in        = luma_ff;
      prev_in        = prev_ff;
      delta_in       = delta_ff;
      ch_in          = ch_ff;
      acc_in         = acc_ff;
      copies_in      = copies_ff;
      tvalid_in      = tvalid_ff;
      fetch_valid_in = fetch_valid_ff;
      wr_en          = 1'b0;

      if (csr.valid) begin
         pixel_count_in = csr.pixel_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               byte_in  = req.chunk_byte;
               state_in = ST_DECODE;
               if (req.first_byte) begin
                  prev_in   = '{8'd0, 8'd0, 8'd0, ALPHA_INIT};
                  kind_in   = KIND_NONE;
                  pend_in   = '0;
                  luma_in   = '0;
                  tvalid_in = '0;
                  left_in   = pixel_count_ff;
               end
            end
         end
         ST_DECODE: begin
            ch_in     = '0;
            acc_in    = '0;
            copies_in = 6'd1;
            state_in  = ST_IDLE;
            if (left_ff != '0) begin
               unique case (kind_ff)
                  KIND_RGB, KIND_RGBA: begin
                     prev_in[rgb_ch[1:0]] = byte_ff;
                     pend_in = pend_ff - 3'd1;
                     if (pend_ff == 3'd1) begin
                        kind_in  = KIND_NONE;
                        state_in = ST_HASH;
                     end
                  end
                  KIND_LUMA: begin
                     delta_in[0] = {4'd0, byte_ff[7:4]} + luma_dg - 8'd8;
                     delta_in[1] = luma_dg;
                     delta_in[2] = {4'd0, byte_ff[3:0]} + luma_dg - 8'd8;
                     kind_in     = KIND_NONE;
                     pend_in     = '0;
                     state_in    = ST_ADD;
                  end
                  default: begin
                     priority if (byte_ff == BYTE_RGB) begin
                        kind_in = KIND_RGB;
                        pend_in = 3'd3;
                     end else if (byte_ff == BYTE_RGBA) begin
                        kind_in = KIND_RGBA;
                        pend_in = 3'd4;
                     end else begin
                        unique case (byte_ff[7:6])
                           2'b00: begin
                              fetch_valid_in = tvalid_ff[byte_ff[TABLE_ADDR_BITS-1:0]];
                              state_in       = ST_FETCH;
                           end
                           2'b01: begin
                              delta_in[0] = {6'd0, byte_ff[5:4]} - 8'd2;
                              delta_in[1] = {6'd0, byte_ff[3:2]} - 8'd2;
                              delta_in[2] = {6'd0, byte_ff[1:0]} - 8'd2;
                              state_in    = ST_ADD;
                           end
                           2'b10: begin
                              luma_in = byte_ff[5:0];
                              kind_in = KIND_LUMA;
                              pend_in = 3'd1;
                           end
                           default: begin
                              copies_in = byte_ff[5:0] + 6'd1;
                              state_in  = ST_HASH;
                           end
                        endcase
                     end
                  end
               endcase
            end
         end
         ST_FETCH: begin
            if (fetch_valid_ff) begin
               prev_in = '{rd_data[7:0], rd_data[15:8], rd_data[23:16], rd_data[31:24]};
            end else begin
               prev_in = '{8'd0, 8'd0, 8'd0, 8'd0};
            end
            state_in = ST_HASH;
         end
         ST_ADD: begin
            prev_in[ch_ff] = sum;
            if (ch_ff == 2'd2) begin
               ch_in    = '0;
               state_in = ST_HASH;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         ST_HASH: begin
            acc_in = sum[TABLE_ADDR_BITS-1:0];
            ch_in  = ch_ff + 2'd1;
            if (ch_ff == 2'd3) begin
               wr_en = 1'b1;
               tvalid_in[sum[TABLE_ADDR_BITS-1:0]] = 1'b1;
               if (left_ff < PIXEL_COUNT_BITS'(copies_ff)) begin
                  copies_in = left_ff[5:0];
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               left_in   = left_ff - PIXEL_COUNT_BITS'(1);
               copies_in = copies_ff - 6'd1;
               if (copies_ff == 6'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         kind_ff        <= KIND_NONE;
         pixel_count_ff <= PIXEL_COUNT_BITS'(1);
         left_ff        <= '0;
         pend_ff        <= '0;
         luma_ff        <= '0;
         prev_ff        <= '{8'd0, 8'd0, 8'd0, ALPHA_INIT};
         ch_ff          <= '0;
         copies_ff      <= '0;
         tvalid_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         kind_ff        <= kind_in;
         pixel_count_ff <= pixel_count_in;
         left_ff        <= left_in;
         pend_ff        <= pend_in;
         luma_ff        <= luma_in;
         prev_ff        <= prev_in;
         ch_ff          <= ch_in;
         copies_ff      <= copies_in;
         tvalid_ff      <= tvalid_in;
      end
      byte_ff        <= byte_in;
      delta_ff       <= delta_in;
      acc_ff         <= acc_in;
      fetch_valid_ff <= fetch_valid_in;
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign csr.ready        = 1'b1;
   assign rsp.valid        = (state_ff == ST_EMIT);
   assign rsp.red          = prev_ff[0];
   assign rsp.green        = prev_ff[1];
   assign rsp.blue         = prev_ff[2];
   assign rsp.alpha        = prev_ff[3];
   assign rsp.last_of_byte = (copies_ff == 6'd1);
   assign rsp.image_end    = (left_ff == PIXEL_COUNT_BITS'(1));

endmodule

### src/lic_checker.sv
// Port-level checker for the chunk decoder and its bind to the top level.
`timescale 1ns / 1ps
module lic_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last_of_byte,
   input logic rsp_image_end
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a pixel is offered");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_last_of_byte)
      else $error("image end without last pixel of byte");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_byte |=> req_ready)
      else $error("not ready after last pixel of byte");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a byte transaction");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_byte |=> rsp_valid)
      else $error("pixel run stopped early");

endmodule

bind lossless_image_chunk_decoder lic_checker u_lic_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_last_of_byte (rsp.last_of_byte),
   .rsp_image_end    (rsp.image_end)
);

### verif/lossless_image_chunk_decoder_tb.sv
// Self-checking testbench for the chunk decoder: byte stream in, RGBA pixels checked.
`timescale 1ns / 1ps
module lossless_image_chunk_decoder_tb;
   import lic_pkg::*;

   localparam int        TARGET_BYTES    = 450;
   localparam int        SETTLE_CYCLES   = 16;
   localparam int        RSP_HOLD_CYCLES = 400;
   localparam int        MAX_REPORTS     = 50;
   localparam longint    TIMEOUT_NS      = 40_000_000;
   localparam count_type PIXEL_COUNT_MAX = '1;

   typedef enum logic [1:0] {OP_INDEX, OP_DIFF, OP_LUMA, OP_RUN} chunk_op_type;
   typedef enum logic [1:0] {CHUNK_NONE, CHUNK_RGB, CHUNK_RGBA, CHUNK_LUMA} chunk_kind_type;

   // color[0] red, [1] green, [2] blue, [3] alpha
   typedef logic [3:0][7:0] rgba_type;

   typedef struct {
      chan_type value;
      logic     first;
   } stream_byte_type;

   typedef struct {
      rgba_type color;
      logic     last_of_byte;
      logic     image_end;
   } decoded_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lic_req_if req_bus ();
   lic_rsp_if rsp_bus ();
   lic_csr_if csr_bus ();

   logic      req_valid = 1'b0;
   chan_type  req_value = '0;
   logic      req_first = 1'b0;
   logic      rsp_ready = 1'b0;
   logic      csr_valid = 1'b0;
   count_type csr_value = '0;

   assign req_bus.valid       = req_valid;
   assign req_bus.chunk_byte  = req_value;
   assign req_bus.first_byte  = req_first;
   assign rsp_bus.ready       = rsp_ready;
   assign csr_bus.valid       = csr_valid;
   assign csr_bus.pixel_count = csr_value;

   lossless_image_chunk_decoder i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   stream_byte_type   chunk_queue [$];
   decoded_pixel_type pixel_queue [$];
   int                mismatch_count = 0;
   int                bytes_consumed = 0;
   int                req_gap_max    = 13;
   int                rsp_gap_max    = 13;
   int                req_gap        = 0;
   int                rsp_wait       = 0;
   int                rsp_hold_left  = 0;
   logic              rsp_hold_armed = 1'b0;
   logic              rsp_hold_taken = 1'b0;
   logic              req_done       = 1'b0;
   logic              rsp_done       = 1'b0;

   // decoder state as predicted
   count_type      pixel_count_cfg = count_type'(1);
   count_type      px_remaining    = '0;
   rgba_type       palette [64];
   rgba_type       last_px         = {8'd255, 8'd0, 8'd0, 8'd0};
   chunk_kind_type open_kind       = CHUNK_NONE;
   int             open_left       = 0;
   int             luma_dg         = 0;

   initial palette = '{default: '0};

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t mismatch %s: got %0h, expected %0h", $time, field, got, want);
   endtask

   function automatic int palette_slot(rgba_type c);
      return (3 * c[0] + 5 * c[1] + 7 * c[2] + 11 * c[3]) % 64;
   endfunction

   task automatic emit_pixels(int copies);
      int                n;
      int                k;
      decoded_pixel_type px;
      n = (copies > px_remaining) ? int'(px_remaining) : copies;
      for (k = 0; k < n; k++) begin
         px_remaining    = px_remaining - count_type'(1);
         px.color        = last_px;
         px.last_of_byte = (k == n - 1);
         px.image_end    = (px_remaining == 0);
         pixel_queue.push_back(px);
      end
      palette[palette_slot(last_px)] = last_px;
   endtask

   task automatic decode_byte(chan_type b, logic first);
      int v;
      int total;
      int dg;
      v = int'(b[5:0]);
      bytes_consumed++;
      if (first) begin
         palette      = '{default: '0};
         last_px      = {ALPHA_INIT, 8'd0, 8'd0, 8'd0};
         open_kind    = CHUNK_NONE;
         open_left    = 0;
         luma_dg      = 0;
         px_remaining = pixel_count_cfg;
      end
      if (px_remaining == 0)
         return;
      case (open_kind)
         CHUNK_RGB, CHUNK_RGBA: begin
            total = (open_kind == CHUNK_RGB) ? 3 : 4;
            last_px[(total - open_left) & 3] = b;
            open_left--;
            if (open_left == 0) begin
               open_kind = CHUNK_NONE;
               emit_pixels(1);
            end
         end
         CHUNK_LUMA: begin
            dg = luma_dg - 32;
            last_px[0] = 8'(last_px[0] + (b >> 4) - 8 + dg);
            last_px[1] = 8'(last_px[1] + dg);
            last_px[2] = 8'(last_px[2] + (b & 8'h0F) - 8 + dg);
            open_kind  = CHUNK_NONE;
            open_left  = 0;
            emit_pixels(1);
         end
         default: begin
            if (b == BYTE_RGB) begin
               open_kind = CHUNK_RGB;
               open_left = 3;
            end else if (b == BYTE_RGBA) begin
               open_kind = CHUNK_RGBA;
               open_left = 4;
            end else begin
               case (b[7:6])
                  OP_INDEX: begin
                     last_px = palette[v];
                     emit_pixels(1);
                  end
                  OP_DIFF: begin
                     last_px[0] = 8'(last_px[0] + b[5:4] - 2);
                     last_px[1] = 8'(last_px[1] + b[3:2] - 2);
                     last_px[2] = 8'(last_px[2] + b[1:0] - 2);
                     emit_pixels(1);
                  end
                  OP_LUMA: begin
                     luma_dg   = v;
                     open_kind = CHUNK_LUMA;
                     open_left = 1;
                  end
                  default: emit_pixels(v + 1);
               endcase
            end
         end
      endcase
   endtask

   // chunk byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else if (!req_valid || req_done) begin
         if (req_gap != 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (chunk_queue.size() != 0) begin
            req_value <= chunk_queue[0].value;
            req_first <= chunk_queue[0].first;
            void'(chunk_queue.pop_front());
            req_valid <= 1'b1;
            req_gap   <= $urandom_range(req_gap_max, 0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_done <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready)
         decode_byte(req_bus.chunk_byte, req_bus.first_byte);
   end

   // pixel receiver: one long hold-off once, otherwise a random wait after each transaction
   always @(negedge clock) begin : rsp_ready_drive
      int wait_cycles;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_hold_armed && !rsp_hold_taken) begin
         rsp_hold_taken <= 1'b1;
         rsp_hold_left  <= RSP_HOLD_CYCLES;
         rsp_ready      <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_ready     <= 1'b0;
      end else if (rsp_done) begin
         wait_cycles = $urandom_range(rsp_gap_max, 0);
         rsp_ready  <= (wait_cycles == 0);
         rsp_wait   <= (wait_cycles == 0) ? 0 : wait_cycles - 1;
      end else if (rsp_wait != 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : pixel_monitor
      decoded_pixel_type want;
      rsp_done <= !reset && rsp_bus.valid && rsp_bus.ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pixel_queue.size() == 0) begin
            report_mismatch("unexpected pixel",
                            {rsp_bus.alpha, rsp_bus.blue, rsp_bus.green, rsp_bus.red}, '0);
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_bus.red !== want.color[0])
               report_mismatch("red", rsp_bus.red, want.color[0]);
            if (rsp_bus.green !== want.color[1])
               report_mismatch("green", rsp_bus.green, want.color[1]);
            if (rsp_bus.blue !== want.color[2])
               report_mismatch("blue", rsp_bus.blue, want.color[2]);
            if (rsp_bus.alpha !== want.color[3])
               report_mismatch("alpha", rsp_bus.alpha, want.color[3]);
            if (rsp_bus.last_of_byte !== want.last_of_byte)
               report_mismatch("last_of_byte", rsp_bus.last_of_byte, want.last_of_byte);
            if (rsp_bus.image_end !== want.image_end)
               report_mismatch("image_end", rsp_bus.image_end, want.image_end);
         end
      end
   end

   task automatic push_byte(chan_type value, logic first);
      stream_byte_type item;
      item.value = value;
      item.first = first;
      chunk_queue.push_back(item);
   endtask

   task automatic push_chunk(logic first);
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) begin
         push_byte(BYTE_RGB, first);
         repeat (3) push_byte(8'($urandom), 1'b0);
      end else if (pick < 22) begin
         push_byte(BYTE_RGBA, first);
         repeat (4) push_byte(8'($urandom), 1'b0);
      end else if (pick < 44) begin
         push_byte({OP_INDEX, 6'($urandom)}, first);
      end else if (pick < 64) begin
         push_byte({OP_DIFF, 6'($urandom)}, first);
      end else if (pick < 82) begin
         push_byte({OP_LUMA, 6'($urandom)}, first);
         push_byte(8'($urandom), 1'b0);
      end else begin
         push_byte({OP_RUN, 6'(($urandom_range(3) == 0) ? $urandom_range(61)
                                                        : $urandom_range(7))}, first);
      end
   endtask

   // lead byte of a multi-byte chunk with its tail cut short
   task automatic push_broken(logic first);
      int pick;
      pick = $urandom_range(2);
      if (pick == 0) begin
         push_byte(BYTE_RGB, first);
         repeat ($urandom_range(2)) push_byte(8'($urandom), 1'b0);
      end else if (pick == 1) begin
         push_byte(BYTE_RGBA, first);
         repeat ($urandom_range(3)) push_byte(8'($urandom), 1'b0);
      end else begin
         push_byte({OP_LUMA, 6'($urandom)}, first);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (chunk_queue.size() != 0 || req_valid || pixel_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_pixel_count(count_type value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_value <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      pixel_count_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_image(count_type img_count, int chunks, logic fresh);
      logic first;
      int   pick;
      wait_idle();
      write_pixel_count(img_count);
      req_gap_max = ($urandom_range(3) == 0) ? 0 : 13;
      rsp_gap_max = ($urandom_range(3) == 0) ? 0 : 13;
      first = fresh;
      repeat (chunks) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            push_byte(8'($urandom), first);
            first = 1'b0;
         end else if (pick < 7) begin
            push_broken(first);
            first = 1'b1;
         end else begin
            push_chunk(first);
            first = 1'b0;
         end
      end
   endtask

   initial begin
      int        pick;
      int        base;
      count_type img_count;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // no image open yet, then a one-pixel image at the reset count with bytes past its end
      push_byte(8'h55, 1'b0);
      push_byte(8'hC5, 1'b0);
      push_byte(8'h7F, 1'b1);
      push_byte(8'h00, 1'b0);
      wait_idle();

      // empty image
      write_pixel_count('0);
      push_byte(8'hC0, 1'b1);
      wait_idle();

      // every chunk kind with extreme values; the receiver stalls while the sender streams
      write_pixel_count(PIXEL_COUNT_MAX);
      req_gap_max    = 0;
      rsp_gap_max    = 0;
      rsp_hold_armed = 1'b1;
      push_byte(BYTE_RGB, 1'b1);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(BYTE_RGBA, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h40, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h3F, 1'b0);
      push_byte(8'hFD, 1'b0);
      push_byte(8'hC0, 1'b0);
      push_byte(BYTE_RGB, 1'b0);
      push_byte(8'h00, 1'b1);
      wait_idle();

      // run clipped at the image end
      write_pixel_count(24'd5);
      req_gap_max = 13;
      rsp_gap_max = 13;
      push_byte(8'hFD, 1'b1);
      push_byte(8'h41, 1'b0);

      base = bytes_consumed;
      while (bytes_consumed - base < TARGET_BYTES) begin
         pick = $urandom_range(19);
         if (pick == 0)
            img_count = '0;
         else if (pick == 1)
            img_count = PIXEL_COUNT_MAX;
         else if (pick < 4)
            img_count = count_type'(1);
         else
            img_count = count_type'($urandom_range(200, 2));
         run_image(img_count, $urandom_range(40, 8), $urandom_range(4) != 0);
      end

      wait_idle();
      if (pixel_queue.size() != 0)
         report_mismatch("pixels never delivered", pixel_queue.size(), 0);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
